[sv/ckx_pkg.sv]
// Shared types, constants and round functions for the ChaCha keystream XOR block.
package ckx_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_WORDS  = 16;
    localparam int BLOCK_W    = WORD_W * NUM_WORDS;
    localparam int REG_W      = 64;
    localparam int ROUNDS_W   = 5;
    localparam int HALF_CNT_W = ROUNDS_W + 1;
    localparam int CFG_IDX_W  = 2;

    localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = ROUNDS_W'(8);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS   = CFG_IDX_W'(3);

    typedef logic [WORD_W-1:0]                word_t;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] block_t;
    typedef logic [3:0][WORD_W-1:0]           quad_t;

    // "expand 16-byte k"
    localparam word_t SIGMA0 = 32'h6170_7865;
    localparam word_t SIGMA1 = 32'h3120_646e;
    localparam word_t SIGMA2 = 32'h7962_2d36;
    localparam word_t SIGMA3 = 32'h6b20_6574;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // take the input word and set up the working state
        logic round;   // apply one half double round
        logic diag;    // diagonal round when set, column round otherwise
        logic finish;  // add the start state, XOR and present the result
    } ckx_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // the output register can take a new result
    } ckx_stat_t;

    function automatic word_t rotl(input word_t v, input int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // q[0]..q[3] are a, b, c, d.
    function automatic quad_t quarter_round(input quad_t q);
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        a = q[0];
        b = q[1];
        c = q[2];
        d = q[3];
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        return {d, c, b, a};
    endfunction

    function automatic block_t init_state(input logic [REG_W-1:0] key_low,
                                          input logic [REG_W-1:0] key_high,
                                          input logic [REG_W-1:0] nonce,
                                          input logic [REG_W-1:0] ctr);
        block_t s;
        s[0]  = SIGMA0;
        s[1]  = SIGMA1;
        s[2]  = SIGMA2;
        s[3]  = SIGMA3;
        s[4]  = key_low[31:0];
        s[5]  = key_low[63:32];
        s[6]  = key_high[31:0];
        s[7]  = key_high[63:32];
        s[8]  = key_low[31:0];
        s[9]  = key_low[63:32];
        s[10] = key_high[31:0];
        s[11] = key_high[63:32];
        s[12] = ctr[31:0];
        s[13] = ctr[63:32];
        s[14] = nonce[31:0];
        s[15] = nonce[63:32];
        return s;
    endfunction

endpackage

[sv/chacha_keystream_xor.sv]
// Top level: ChaCha keystream XOR over 64-byte words, with configuration registers.
// Each accepted word is loaded, run through the single half double round unit, which is
// iterated in place, and finished; a new word is taken only once the previous one is
// finished, and the finish step waits while the output register is still full.
// A finished result waits in the output register while the next word is taken.
// Reset clears the block counter and the key and nonce registers and sets rounds to 8.
module chacha_keystream_xor (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // data_word_0 .. data_word_7, 64 bits each
    input  logic [ckx_pkg::BLOCK_W-1:0]          s_tdata,
    // restart
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_word_0 .. out_word_7, 64 bits each
    output logic [ckx_pkg::BLOCK_W-1:0]          m_tdata,
    input  logic                                 cfg_we,
    input  logic [ckx_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ckx_pkg::REG_W-1:0]            cfg_data
);
    import ckx_pkg::*;

    logic [REG_W-1:0]     key_low_reg;
    logic [REG_W-1:0]     key_high_reg;
    logic [REG_W-1:0]     nonce_reg;
    logic [ROUNDS_W-1:0]  rounds_reg;
    ckx_cmd_t             cmd;
    ckx_stat_t            stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            nonce_reg    <= '0;
            rounds_reg   <= ROUNDS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_NONCE:    nonce_reg    <= cfg_data;
                CFG_ROUNDS:   rounds_reg   <= cfg_data[ROUNDS_W-1:0];
                default:      ;
            endcase
        end
    end

    ckx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .rounds   (rounds_reg),
        .stat     (stat),
        .cmd      (cmd)
    );

    ckx_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .key_low  (key_low_reg),
        .key_high (key_high_reg),
        .nonce    (nonce_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // One word at a time: after a word is taken the input side closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again while a word is in work");

    // A result only appears at the end of a busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result presented without a word in work");

    // The finish step only runs when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && cmd.finish) |-> 1'b0)
        else $error("result overwritten while still waiting");

endmodule

[sv/ckx_ctrl.sv]
// Controller state machine: sequences load, half double rounds and the final add.
module ckx_ctrl (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [ckx_pkg::ROUNDS_W-1:0]          rounds,
    input  ckx_pkg::ckx_stat_t                    stat,
    output ckx_pkg::ckx_cmd_t                     cmd
);
    import ckx_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [HALF_CNT_W-1:0]   half_cnt_reg;
    logic [HALF_CNT_W-1:0]   half_cnt_next;
    logic [HALF_CNT_W-1:0]   half_total;

    // Odd round counts round up to the next even count of half rounds.
    assign half_total = HALF_CNT_W'(rounds) + HALF_CNT_W'(rounds[0]);

    always_comb
    begin
        state_next    = state_reg;
        half_cnt_next = half_cnt_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load      = 1'b1;
                    half_cnt_next = half_total;
                    state_next    = (half_total == '0) ? ST_FINISH : ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                // The count starts even, so an even remainder means a column round.
                cmd.round     = 1'b1;
                cmd.diag      = half_cnt_reg[0];
                half_cnt_next = half_cnt_reg - HALF_CNT_W'(1);
                if (half_cnt_reg == HALF_CNT_W'(1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            half_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            half_cnt_reg <= half_cnt_next;
        end
    end

endmodule

[sv/ckx_datapath.sv]
// Datapath: working state, one half double round unit, block counter and output register.
module ckx_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ckx_pkg::ckx_cmd_t                 cmd,
    output ckx_pkg::ckx_stat_t                stat,
    input  logic [ckx_pkg::BLOCK_W-1:0]       s_tdata,
    input  logic                              s_tuser,
    input  logic [ckx_pkg::REG_W-1:0]         key_low,
    input  logic [ckx_pkg::REG_W-1:0]         key_high,
    input  logic [ckx_pkg::REG_W-1:0]         nonce,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ckx_pkg::BLOCK_W-1:0]       m_tdata
);
    import ckx_pkg::*;

    block_t              work_reg;
    block_t              work_next;
    block_t              work_round;
    logic [BLOCK_W-1:0]  data_reg;
    logic [BLOCK_W-1:0]  out_reg;
    logic                out_valid_reg;
    logic [REG_W-1:0]    block_ctr_reg;
    logic [REG_W-1:0]    load_ctr;
    block_t              init_load;
    block_t              init_cur;
    block_t              keystream;

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_reg;

    assign load_ctr  = s_tuser ? '0 : block_ctr_reg;
    assign init_load = init_state(key_low, key_high, nonce, load_ctr);
    assign init_cur  = init_state(key_low, key_high, nonce, block_ctr_reg);

    // Four quarter rounds side by side: a column round or a diagonal round.
    always_comb
    begin
        quad_t q;
        work_round = work_reg;
        for (int i = 0; i < 4; i++)
        begin
            if (cmd.diag)
            begin
                q = quarter_round({work_reg[12 + ((i + 3) % 4)], work_reg[8 + ((i + 2) % 4)],
                                   work_reg[4 + ((i + 1) % 4)], work_reg[i]});
                work_round[i]                   = q[0];
                work_round[4 + ((i + 1) % 4)]   = q[1];
                work_round[8 + ((i + 2) % 4)]   = q[2];
                work_round[12 + ((i + 3) % 4)]  = q[3];
            end
            else
            begin
                q = quarter_round({work_reg[12 + i], work_reg[8 + i],
                                   work_reg[4 + i], work_reg[i]});
                work_round[i]      = q[0];
                work_round[4 + i]  = q[1];
                work_round[8 + i]  = q[2];
                work_round[12 + i] = q[3];
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_WORDS; j++)
        begin
            keystream[j] = work_reg[j] + init_cur[j];
        end
    end

    always_comb
    begin
        work_next = work_reg;
        if (cmd.load)
        begin
            work_next = init_load;
        end
        else if (cmd.round)
        begin
            work_next = work_round;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (cmd.load)
        begin
            data_reg <= s_tdata;
        end
        if (cmd.finish)
        begin
            out_reg <= data_reg ^ keystream;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            block_ctr_reg <= '0;
        end
        else
        begin
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                block_ctr_reg <= load_ctr;
            end
            else if (cmd.finish)
            begin
                block_ctr_reg <= block_ctr_reg + REG_W'(1);
            end
        end
    end

endmodule

[tb/chacha_keystream_xor_test.sv]
// Self-checking testbench for the ChaCha keystream XOR block, with its own keystream predictor.
module chacha_keystream_xor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ckx_pkg::*;

    typedef logic [BLOCK_W-1:0] msg_t;

    localparam int TOTAL_ITEMS    = 1550;
    localparam int STALL_LIMIT    = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT_FIRST  = 300;
    localparam int HOLD_AT_SECOND = 1100;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        bit          load_cfg;
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        logic [63:0] iv;
        logic [63:0] rounds_word;
        logic        restart;
        msg_t        msg;
        bit          known;
        msg_t        known_out;
    } vector_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [BLOCK_W-1:0]   s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [BLOCK_W-1:0]   m_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;

    // Predictor copy of the configuration and the block counter.
    logic [63:0]          key_lo_q;
    logic [63:0]          key_hi_q;
    logic [63:0]          iv_q;
    logic [ROUNDS_W-1:0]  rounds_q;
    logic [63:0]          block_count;

    msg_t                 xored_blocks[$];
    vector_t              vectors[$];
    int                   mismatch_count = 0;
    int                   items_sent = 0;
    int                   idle_cycles = 0;
    int                   burst_left = 0;
    int                   flood_left = 0;
    bit                   hold_request = 1'b0;

    chacha_keystream_xor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic word_t rot_left(input word_t v, input int unsigned n);
        logic [63:0] twice;
        twice = {v, v} << n;
        return twice[63:32];
    endfunction

    function automatic msg_t keystream_xor(input logic restart, input msg_t msg);
        word_t start[16];
        word_t x[16];
        int    a, b, c, d;
        int    dbl;
        msg_t  res;
        if (restart)
            block_count = '0;
        // "expand 16-byte k" as four little-endian words
        start[0]  = 32'h6170_7865;
        start[1]  = 32'h3120_646e;
        start[2]  = 32'h7962_2d36;
        start[3]  = 32'h6b20_6574;
        start[4]  = key_lo_q[31:0];
        start[5]  = key_lo_q[63:32];
        start[6]  = key_hi_q[31:0];
        start[7]  = key_hi_q[63:32];
        for (int i = 0; i < 4; i++)
            start[8 + i] = start[4 + i];
        start[12] = block_count[31:0];
        start[13] = block_count[63:32];
        start[14] = iv_q[31:0];
        start[15] = iv_q[63:32];
        x = start;
        dbl = (int'(rounds_q) + 1) / 2;
        // Pass 0 mixes the columns, pass 1 the diagonals.
        for (int k = 0; k < dbl; k++)
        begin
            for (int pass = 0; pass < 2; pass++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    a = i;
                    b = 4 + (i + pass) % 4;
                    c = 8 + (i + 2 * pass) % 4;
                    d = 12 + (i + 3 * pass) % 4;
                    x[a] = x[a] + x[b]; x[d] = rot_left(x[d] ^ x[a], 16);
                    x[c] = x[c] + x[d]; x[b] = rot_left(x[b] ^ x[c], 12);
                    x[a] = x[a] + x[b]; x[d] = rot_left(x[d] ^ x[a], 8);
                    x[c] = x[c] + x[d]; x[b] = rot_left(x[b] ^ x[c], 7);
                end
            end
        end
        for (int j = 0; j < 16; j++)
            x[j] = x[j] + start[j];
        for (int w = 0; w < 8; w++)
            res[64 * w +: 64] = msg[64 * w +: 64] ^ {x[2 * w + 1], x[2 * w]};
        block_count = block_count + 64'd1;
        return res;
    endfunction

    function automatic void log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, what);
    endfunction

    function automatic logic [63:0] rand_word64();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic msg_t rand_msg();
        msg_t m;
        for (int w = 0; w < 8; w++)
            m[64 * w +: 64] = rand_word64();
        return m;
    endfunction

    function automatic void add_row(input bit load_cfg, input logic [63:0] kl,
                                    input logic [63:0] kh, input logic [63:0] iv,
                                    input logic [63:0] rw, input logic restart,
                                    input msg_t msg, input bit known, input msg_t known_out);
        vector_t v;
        v.load_cfg    = load_cfg;
        v.key_lo      = kl;
        v.key_hi      = kh;
        v.iv          = iv;
        v.rounds_word = rw;
        v.restart     = restart;
        v.msg         = msg;
        v.known       = known;
        v.known_out   = known_out;
        vectors.push_back(v);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_KEY_LOW:  key_lo_q = value;
            CFG_KEY_HIGH: key_hi_q = value;
            CFG_NONCE:    iv_q = value;
            CFG_ROUNDS:   rounds_q = value[ROUNDS_W-1:0];
            default: ;
        endcase
    endtask

    // Registers change only once every outstanding word has come back.
    task automatic program_regs(input logic [63:0] kl, input logic [63:0] kh,
                                input logic [63:0] iv, input logic [63:0] rw);
        s_tvalid <= 1'b0;
        while (xored_blocks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_ROUNDS, rw);
        write_reg(CFG_NONCE, iv);
        write_reg(CFG_KEY_HIGH, kh);
        write_reg(CFG_KEY_LOW, kl);
        cfg_we <= 1'b0;
    endtask

    task automatic send_block(input logic restart, input msg_t msg,
                              input bit known, input msg_t known_out);
        msg_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= restart;
        s_tdata  <= msg;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = keystream_xor(restart, msg);
        xored_blocks.push_back(known ? known_out : predicted);
        items_sent++;
    endtask

    task automatic pace();
        int gap;
        gap = 0;
        if (flood_left > 0)
            flood_left--;
        else if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin : sink
        int style;
        int run_len;
        m_tready <= 1'b0;
        forever
        begin
            style = $urandom_range(0, 3);
            run_len = $urandom_range(8, 80);
            for (int n = 0; n < run_len && !hold_request; n++)
            begin
                @(posedge clk);
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 5) == 0);
                    default: m_tready <= (n % 3 == 2);
                endcase
            end
            if (hold_request)
            begin
                @(posedge clk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
        end
    end

    initial
    begin : result_check
        msg_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (xored_blocks.size() == 0)
                    log_mismatch($sformatf("unexpected word %h", m_tdata));
                else
                begin
                    want = xored_blocks.pop_front();
                    for (int w = 0; w < 8; w++)
                        if (m_tdata[64 * w +: 64] !== want[64 * w +: 64])
                            log_mismatch($sformatf("out_word_%0d expected %h got %h", w,
                                                   want[64 * w +: 64], m_tdata[64 * w +: 64]));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        msg_t        zeros;
        msg_t        ones;
        msg_t        m55;
        msg_t        maa;
        msg_t        mcnt;
        logic [63:0] ka;
        logic [63:0] kb;
        logic [63:0] iva;
        logic [63:0] rw;
        int          pick;
        int          phase_len;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_KEY_LOW;
        cfg_data  <= '0;
        key_lo_q    = '0;
        key_hi_q    = '0;
        iv_q        = '0;
        rounds_q    = 5'd8;
        block_count = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        zeros = '0;
        ones  = '1;
        m55   = {8{64'h5555_5555_5555_5555}};
        maa   = {8{64'hAAAA_AAAA_AAAA_AAAA}};
        mcnt  = {8{64'h0123_4567_89AB_CDEF}};
        ka    = 64'h0706_0504_0302_0100;
        kb    = 64'h0F0E_0D0C_0B0A_0908;
        iva   = 64'h4A00_0000_0900_0000;

        // Reset defaults: zero key and nonce, eight rounds, counter at zero.
        add_row(1'b0, '0, '0, '0, '0, 1'b0, zeros, 1'b0, '0);
        // With no rounds the keystream is the start state doubled.
        add_row(1'b1, '0, '0, '0, 64'd0, 1'b1, zeros, 1'b1,
                {384'h0, 64'hD640_CAE8_F2C4_5A6C, 64'h6240_C8DC_C2E0_F0CA});
        add_row(1'b0, '0, '0, '0, '0, 1'b0, ones, 1'b1,
                {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFD, {4{64'hFFFF_FFFF_FFFF_FFFF}},
                 64'h29BF_3517_0D3B_A593, 64'h9DBF_3723_3D1F_0F35});
        // Upper bits of a rounds write are dropped.
        add_row(1'b1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFE8, 1'b1, zeros, 1'b0, '0);
        add_row(1'b0, '0, '0, '0, '0, 1'b0, ones, 1'b0, '0);
        add_row(1'b0, '0, '0, '0, '0, 1'b0, m55, 1'b0, '0);
        add_row(1'b0, '0, '0, '0, '0, 1'b0, maa, 1'b0, '0);
        // Odd counts round up to the next even count.
        add_row(1'b1, ka, kb, iva, 64'd1, 1'b1, mcnt, 1'b0, '0);
        add_row(1'b1, ka, kb, iva, 64'd2, 1'b0, mcnt, 1'b0, '0);
        add_row(1'b1, ka, kb, iva, 64'd7, 1'b0, m55, 1'b0, '0);
        add_row(1'b1, ka, kb, iva, 64'd20, 1'b1, zeros, 1'b0, '0);
        add_row(1'b0, '0, '0, '0, '0, 1'b0, ones, 1'b0, '0);
        // Counts above twenty are not limited to twenty; odd ones still round up.
        add_row(1'b1, ka, kb, iva, 64'd21, 1'b0, maa, 1'b0, '0);
        add_row(1'b1, kb, ka, '1, 64'd31, 1'b1, mcnt, 1'b0, '0);
        add_row(1'b0, '0, '0, '0, '0, 1'b0, mcnt, 1'b0, '0);
        add_row(1'b0, '0, '0, '0, '0, 1'b1, mcnt, 1'b0, '0);
        // The counter carries on across a register change.
        add_row(1'b1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                64'hAAAA_AAAA_AAAA_AAAA, 64'd12, 1'b0, ones, 1'b0, '0);
        add_row(1'b0, '0, '0, '0, '0, 1'b0, zeros, 1'b0, '0);

        foreach (vectors[i])
        begin
            if (vectors[i].load_cfg)
                program_regs(vectors[i].key_lo, vectors[i].key_hi, vectors[i].iv,
                             vectors[i].rounds_word);
            send_block(vectors[i].restart, vectors[i].msg, vectors[i].known,
                       vectors[i].known_out);
            pace();
        end

        while (items_sent < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            rw = {$urandom, $urandom};
            case (pick)
                0, 1: rw[ROUNDS_W-1:0] = 5'd8;
                2: rw[ROUNDS_W-1:0] = 5'd20;
                3: rw[ROUNDS_W-1:0] = 5'd12;
                4: rw[ROUNDS_W-1:0] = 5'd0;
                5: rw[ROUNDS_W-1:0] = 5'd31;
                6: rw[ROUNDS_W-1:0] = 5'd1;
                default: rw[ROUNDS_W-1:0] = ROUNDS_W'($urandom_range(0, 31));
            endcase
            program_regs(rand_word64(), rand_word64(), rand_word64(), rw);
            phase_len = $urandom_range(10, 120);
            for (int n = 0; n < phase_len && items_sent < TOTAL_ITEMS; n++)
            begin
                // Stop the output for a long stretch while words keep coming in.
                if (items_sent == HOLD_AT_FIRST || items_sent == HOLD_AT_SECOND)
                begin
                    hold_request = 1'b1;
                    flood_left = 40;
                end
                send_block(($urandom_range(0, 15) == 0), rand_msg(), 1'b0, '0);
                pace();
            end
        end
        s_tvalid <= 1'b0;

        while (xored_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (xored_blocks.size() != 0)
            $display("%0d words never came back", xored_blocks.size());
        if (mismatch_count == 0 && xored_blocks.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
